FILE: hw/rtl/sobel_pkg.sv
// Package for the Sobel edge magnitude block: constants and types.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sobel_pkg;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam logic [10:0] WIDTH_RESET = 11'd1024;
    localparam logic [15:0] HEIGHT_RESET = 16'd768;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [0:0] REG_WIDTH = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    // one classified item handed from front to back
    typedef struct packed {
        logic [23:0] p00, p01, p02;   // left column, top to bottom
        logic [23:0] p10, p11, p12;   // centre column
        logic [23:0] p20, p21, p22;   // right column
        logic        last;
    } t_job;
endpackage
`default_nettype wire

FILE: hw/rtl/sobel_front.sv
// Front part: positions, line stores and window; emits one job per result.
// Depends on sobel_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sobel_front #(
    parameter int MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_restart,
    input  wire logic [10:0]      i_width,
    input  wire logic [15:0]      i_height,
    input  wire logic             i_push,
    input  wire logic             i_mode,
    input  wire logic [23:0]      i_px,
    output sobel_pkg::t_job       o_job,
    output logic                  o_job_valid,
    output logic                  o_busy
);
    localparam int AW = $clog2(MAX_WIDTH);

    logic [23:0] r_upper [MAX_WIDTH];
    logic [23:0] r_middle [MAX_WIDTH];
    logic [23:0] r_win [3][3];
    logic [11:0] r_col;
    logic [16:0] r_row;
    logic        r_busy;
    logic [11:0] r_j;
    logic [16:0] r_i;
    logic        r_wrap;
    logic [23:0] r_px, r_a, r_b;

    logic [11:0] w_eff;
    logic [16:0] h_eff;
    logic [11:0] j;
    logic [16:0] i;
    logic        wrap;
    logic [23:0] px;
    logic [AW-1:0] addr;

    assign o_busy = r_busy;

    always_comb begin
        w_eff = {1'b0, i_width};
        if (i_width == 11'd0) w_eff = 12'd1;
        if (int'(w_eff) > MAX_WIDTH) w_eff = 12'(MAX_WIDTH);
        h_eff = {1'b0, i_height};
        if (i_height == 16'd0) h_eff = 17'd1;
        wrap = (r_col >= w_eff) || (r_row > h_eff + 17'd1);
        j = wrap ? 12'd0 : r_col;
        i = wrap ? 17'd0 : r_row;
        px = (!i_mode && i < h_eff) ? i_px : 24'd0;
        addr = j[AW-1:0];
    end

    // read the stores on the transfer, write them back on the following cycle
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_a <= r_upper[addr];
            r_b <= r_middle[addr];
        end
        if (r_busy) begin
            r_upper[r_j[AW-1:0]] <= r_b;
            r_middle[r_j[AW-1:0]] <= r_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col <= '0;
            r_row <= '0;
            r_busy <= 1'b0;
            for (int c = 0; c < 3; c++)
                for (int k = 0; k < 3; k++) r_win[c][k] <= '0;
            o_job_valid <= 1'b0;
        end else begin
            o_job_valid <= 1'b0;
            if (r_busy) begin
                r_busy <= 1'b0;
                for (int k = 0; k < 3; k++) begin
                    r_win[0][k] <= r_wrap ? 24'd0 : r_win[1][k];
                    r_win[1][k] <= r_wrap ? 24'd0 : r_win[2][k];
                end
                r_win[2][0] <= r_a;
                r_win[2][1] <= r_b;
                r_win[2][2] <= r_px;
                if (r_j == 12'd0 && r_i >= 17'd2) begin
                    o_job_valid <= 1'b1;
                    o_job.p00 <= (w_eff == 12'd1 || r_i == 17'd2) ? 24'd0 : r_win[1][0];
                    o_job.p01 <= (w_eff == 12'd1) ? 24'd0 : r_win[1][1];
                    o_job.p02 <= (w_eff == 12'd1) ? 24'd0 : r_win[1][2];
                    o_job.p10 <= (r_i == 17'd2) ? 24'd0 : r_win[2][0];
                    o_job.p11 <= r_win[2][1];
                    o_job.p12 <= r_win[2][2];
                    o_job.p20 <= '0;
                    o_job.p21 <= '0;
                    o_job.p22 <= '0;
                    o_job.last <= (r_i == h_eff + 17'd1);
                end else if (r_j >= 12'd1 && r_i >= 17'd1 && r_i <= h_eff) begin
                    o_job_valid <= 1'b1;
                    o_job.p00 <= (r_j == 12'd1 || r_i == 17'd1) ? 24'd0 : r_win[1][0];
                    o_job.p01 <= (r_j == 12'd1) ? 24'd0 : r_win[1][1];
                    o_job.p02 <= (r_j == 12'd1) ? 24'd0 : r_win[1][2];
                    o_job.p10 <= (r_i == 17'd1) ? 24'd0 : r_win[2][0];
                    o_job.p11 <= r_win[2][1];
                    o_job.p12 <= r_win[2][2];
                    o_job.p20 <= (r_i == 17'd1) ? 24'd0 : r_a;
                    o_job.p21 <= r_b;
                    o_job.p22 <= r_px;
                    o_job.last <= 1'b0;
                end
                if (r_i == h_eff + 17'd1) begin
                    r_col <= '0;
                    r_row <= '0;
                end else if (r_j + 12'd1 >= w_eff) begin
                    r_col <= '0;
                    r_row <= r_i + 17'd1;
                end else begin
                    r_col <= r_j + 12'd1;
                    r_row <= r_i;
                end
            end else if (i_push) begin
                r_busy <= 1'b1;
                r_j <= j;
                r_i <= i;
                r_wrap <= wrap;
                r_px <= px;
            end
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/sobel_queue.sv
// Short job queue between the front and back parts.
// Depends on sobel_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sobel_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire sobel_pkg::t_job  i_data,
    input  wire logic             i_rd,
    output sobel_pkg::t_job       o_data,
    output logic                  o_empty,
    output logic [2:0]            o_count
);
    sobel_pkg::t_job r_mem [sobel_pkg::QUEUE_DEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    assign o_data = r_mem[r_rp];
    assign o_empty = (r_cnt == 3'd0);
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) r_wp <= r_wp + 2'd1;
            if (i_rd) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, i_wr} - {2'd0, i_rd};
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/sobel_back.sv
// Back part: gradients, squares and per-channel rounded square root, one
// root bit per cycle. Depends on sobel_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sobel_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire sobel_pkg::t_job  i_job,
    input  wire logic             i_job_empty,
    output logic                  o_job_take,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [7:0]            o_blue,
    output logic [7:0]            o_green,
    output logic [7:0]            o_red,
    output logic                  o_last
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SQ   = 2'd1;
    localparam logic [1:0] ST_ROOT = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]  r_st;
    logic [11:0] r_gx [3];
    logic [11:0] r_gy [3];
    logic [20:0] r_s [3];
    logic [7:0]  r_n [3];
    logic [7:0]  r_bit;
    logic        r_last;

    function automatic logic [11:0] grad(input logic [7:0] p0, p1, p2, m0, m1, m2);
        return 12'({4'd0, p0} + {3'd0, p1, 1'b0} + {4'd0, p2})
             - 12'({4'd0, m0} + {3'd0, m1, 1'b0} + {4'd0, m2});
    endfunction

    // square of a signed gradient, sign-extended before the multiply
    function automatic logic [20:0] square(input logic [11:0] g);
        logic signed [20:0] gs;
        gs = 21'($signed(g));
        return gs * gs;
    endfunction

    assign o_job_take = (r_st == ST_IDLE) && !i_job_empty;
    assign o_empty = (r_st != ST_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
        end else begin
            case (r_st)
                ST_IDLE: begin
                    if (!i_job_empty) begin
                        for (int c = 0; c < 3; c++) begin
                            r_gx[c] <= grad(i_job.p20[8*c+:8], i_job.p21[8*c+:8],
                                i_job.p22[8*c+:8], i_job.p00[8*c+:8],
                                i_job.p01[8*c+:8], i_job.p02[8*c+:8]);
                            r_gy[c] <= grad(i_job.p02[8*c+:8], i_job.p12[8*c+:8],
                                i_job.p22[8*c+:8], i_job.p00[8*c+:8],
                                i_job.p10[8*c+:8], i_job.p20[8*c+:8]);
                        end
                        r_last <= i_job.last;
                        r_st <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    for (int c = 0; c < 3; c++) begin
                        r_s[c] <= square(r_gx[c]) + square(r_gy[c]);
                        r_n[c] <= '0;
                    end
                    r_bit <= 8'h80;
                    r_st <= ST_ROOT;
                end
                ST_ROOT: begin
                    if (r_bit == 8'd0) begin
                        // round up when s exceeds n*n+n; clamp large sums
                        for (int c = 0; c < 3; c++) begin
                            if (r_s[c] >= 21'd65281) r_n[c] <= 8'd255;
                            else if (r_s[c] > 21'({8'd0, r_n[c]} * {8'd0, r_n[c]}
                                               + {8'd0, r_n[c]}))
                                r_n[c] <= r_n[c] + 8'd1;
                        end
                        r_st <= ST_OUT;
                    end else begin
                        for (int c = 0; c < 3; c++)
                            if (21'({8'd0, r_n[c] | r_bit} * {8'd0, r_n[c] | r_bit})
                                <= r_s[c])
                                r_n[c] <= r_n[c] | r_bit;
                        r_bit <= r_bit >> 1;
                    end
                end
                ST_OUT: begin
                    if (i_pop) r_st <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign o_blue = r_n[0];
    assign o_green = r_n[1];
    assign o_red = r_n[2];
    assign o_last = r_last;
endmodule
`default_nettype wire

FILE: hw/rtl/sobel_edge_magnitude_top.sv
// Top level of the Sobel edge magnitude block: APB registers, front, queue, back.
// Depends on sobel_pkg, sobel_front, sobel_queue, sobel_back.
`timescale 1ns / 1ps
`default_nettype none
// Streams RGB pixels in raster order and returns round(sqrt(gx^2+gy^2))
// clamped to 255 for each channel, borders treated as zero. The result for
// a pixel follows one row plus one pixel later; after a frame send width+1
// flush items to drain it. The front finishes each item (a registered
// line-store read, then the window update) before it takes the next, and
// takes items only while the job queue has room; the back end works each
// result through gradient, square, eight root bits, rounding and hand-over
// before it takes the next job, so the bit-serial square root sets the pace
// of frames of mostly result-bearing items. Program width and height only
// while idle: a write restarts the frame.
module sobel_edge_magnitude_top #(
    parameter int MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:2]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_mode,
    input  wire logic [7:0]  i_in_blue,
    input  wire logic [7:0]  i_in_green,
    input  wire logic [7:0]  i_in_red,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_out_blue,
    output logic [7:0]       o_out_green,
    output logic [7:0]       o_out_red,
    output logic             o_frame_last
);
    logic [10:0] r_width;
    logic [15:0] r_height;
    logic        wr;
    logic        accept;
    logic        take;
    logic        qempty;
    logic [2:0]  qcount;
    logic        job_valid;
    logic        front_busy;
    sobel_pkg::t_job job, qjob;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= sobel_pkg::WIDTH_RESET;
            r_height <= sobel_pkg::HEIGHT_RESET;
        end else if (wr) begin
            case (paddr[2])
                sobel_pkg::REG_WIDTH: r_width <= pwdata[10:0];
                sobel_pkg::REG_HEIGHT: r_height <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            sobel_pkg::REG_WIDTH: prdata = {21'd0, r_width};
            default: prdata = {16'd0, r_height};
        endcase
    end

    // hold input while the front finishes an item, or while the queue,
    // counting the job in flight, could overflow
    assign full = front_busy || ((qcount + {2'd0, job_valid}) >= 3'd3);
    assign accept = push && !full;

    sobel_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_restart(wr),
        .i_width(r_width), .i_height(r_height),
        .i_push(accept), .i_mode(i_mode),
        .i_px({i_in_red, i_in_green, i_in_blue}),
        .o_job(job), .o_job_valid(job_valid), .o_busy(front_busy)
    );

    sobel_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(job_valid), .i_data(job),
        .i_rd(take), .o_data(qjob), .o_empty(qempty), .o_count(qcount)
    );

    sobel_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job(qjob), .i_job_empty(qempty),
        .o_job_take(take), .i_pop(pop), .o_empty(empty),
        .o_blue(o_out_blue), .o_green(o_out_green), .o_red(o_out_red),
        .o_last(o_frame_last)
    );
endmodule
`default_nettype wire
